/* rtl/bf16_weight_matvec_accumulator_assert.svh */
// Assertion macros shared by the checker of the BF16 matrix-vector accumulator.
// Both macros expect signals named clk and rst_n in the scope where they are used.
`ifndef BF16_WEIGHT_MATVEC_ACCUMULATOR_ASSERT_SVH
`define BF16_WEIGHT_MATVEC_ACCUMULATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BMV_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bf16 matvec check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BMV_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bf16 matvec check failed");

`endif

/* rtl/bf16mv_pkg.sv */
// Shared types and constants for the BF16 weight matrix-vector accumulator.
// Used by the top level and by its port checker; depends on nothing else.
package bf16mv_pkg;

  localparam int MAX_ROWS    = 4096;
  localparam int MAX_COLS    = 4096;
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int COL_W       = 12;
  localparam int CFG_W       = 13;
  localparam int VAL_W       = 32;
  localparam int BF_W        = 16;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 48;
  localparam int WIN_W       = 90;
  localparam int SUM_W       = 91;

  localparam logic [VAL_W-1:0] CANON_NAN = 32'h7FC0_0000;

  typedef enum logic [1:0] {
    CMD_ACC  = 2'd0,
    CMD_CLR  = 2'd1,
    CMD_READ = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    REG_ROW_FIRST = 2'd0,
    REG_ROW_END   = 2'd1,
    REG_COL_FIRST = 2'd2,
    REG_COL_END   = 2'd3
  } reg_idx_t;

endpackage

/* rtl/bf16_weight_matvec_accumulator.sv */
// Top level of the BF16 weight matrix-vector accumulator: row store, FP32 fused
// multiply-add datapath and command sequencer. Depends on bf16mv_pkg.
//
//  Channel | Direction | Signals                              | Word
//  in      | sink      | in_tvalid/in_tready/in_tdata/in_tuser | one command
//  out     | source    | out_tvalid/out_tready/out_tdata       | one row read back
//  cfg     | sink      | cfg_valid/cfg_ready/cfg_index/cfg_data | one window register
//
// An accumulate word in the windows passes through the read of the row store,
// six steps of the fused multiply-add and the write back, one word at a time.
// Clear and ignored words keep the sequencer idle; a read word holds in read-out
// through any out-channel stall, and the next word is taken while its result waits.
// rst_n is synchronous and active low; the row store is not cleared by it.
module bf16_weight_matvec_accumulator
  import bf16mv_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // row_index[11:0], col_index[23:12], weight_bits[39:24], vector_bits[71:40]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // command[1:0]
  input  logic [1:0]             in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // row_value[31:0], row_number[43:32], zero fill[47:44]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_DEC, ST_ALN, ST_ADD, ST_NRM1, ST_NRM2, ST_SHF, ST_RND, ST_RDO
  } state_t;

  state_t state_r;

  logic [CFG_W-1:0] row_first_r, row_end_r, col_first_r, col_end_r;

  // Row store.
  logic [VAL_W-1:0] acc_mem [MAX_ROWS];
  logic [VAL_W-1:0] rdata_r;
  logic             mem_re, mem_we;
  logic [ROW_W-1:0] mem_waddr;
  logic [VAL_W-1:0] mem_wdata;

  // Captured word.
  logic [ROW_W-1:0] row_r;
  logic [VAL_W-1:0] x_r;
  logic [BF_W-1:0]  w_r;

  // Datapath registers.
  logic [31:0]        pm_r;
  logic [23:0]        mc_r;
  logic               sp_r, sc_r, sg_r;
  logic [6:0]         rp_r, rc_r;
  logic signed [10:0] e0_r;
  logic               spec_r;
  logic [VAL_W-1:0]   spec_val_r;
  logic [WIN_W-1:0]   pal_r, cal_r;
  logic [SUM_W-1:0]   s_r;
  logic [5:0]         nz_r;
  logic [3:0]         pos_r [6];
  logic [6:0]         l_r;
  logic [23:0]        m_r;
  logic               rnd_r, stk_r;
  logic signed [10:0] ef_r;

  logic                   out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  // Input fields.
  logic [ROW_W-1:0] in_row;
  logic [COL_W-1:0] in_col;
  logic             in_acc, row_win, col_win;

  assign in_row    = in_tdata[11:0];
  assign in_col    = in_tdata[23:12];
  assign in_acc    = in_tvalid && in_tready;
  assign row_win   = ({1'b0, in_row} >= row_first_r) && ({1'b0, in_row} < row_end_r);
  assign col_win   = ({1'b0, in_col} >= col_first_r) && ({1'b0, in_col} < col_end_r);
  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // Decode step: unpack operands, flag special cases, multiply and plan alignment.
  logic [7:0]         ea, eb, ec, ea_e, eb_e, ec_e;
  logic [23:0]        ma, mc;
  logic [7:0]         mb;
  logic signed [10:0] ep, ecu, dd, sh_p, sh_c;
  logic               nan_a, nan_b, nan_c, inf_a, inf_b, inf_c, zero_a, zero_b;
  logic               sp_nxt, prod_inf, is_nan, zero_p;
  logic [31:0]        pm_nxt;
  logic [6:0]         rp_nxt, rc_nxt;
  logic signed [10:0] e0_nxt;
  logic [VAL_W-1:0]   spec_val_nxt;

  always_comb begin
    ea = x_r[30:23];
    eb = w_r[14:7];
    ec = rdata_r[30:23];
    ma = {(ea != 8'd0), x_r[22:0]};
    mb = {(eb != 8'd0), w_r[6:0]};
    mc = {(ec != 8'd0), rdata_r[22:0]};
    ea_e = (ea == 8'd0) ? 8'd1 : ea;
    eb_e = (eb == 8'd0) ? 8'd1 : eb;
    ec_e = (ec == 8'd0) ? 8'd1 : ec;
    ep  = $signed({3'b000, ea_e}) + $signed({3'b000, eb_e}) - 11'sd284;
    ecu = $signed({3'b000, ec_e}) - 11'sd150;
    dd  = ecu - ep;
    nan_a  = (ea == 8'hFF) && (x_r[22:0] != 23'd0);
    inf_a  = (ea == 8'hFF) && (x_r[22:0] == 23'd0);
    zero_a = (ea == 8'd0) && (x_r[22:0] == 23'd0);
    nan_b  = (eb == 8'hFF) && (w_r[6:0] != 7'd0);
    inf_b  = (eb == 8'hFF) && (w_r[6:0] == 7'd0);
    zero_b = (eb == 8'd0) && (w_r[6:0] == 7'd0);
    nan_c  = (ec == 8'hFF) && (rdata_r[22:0] != 23'd0);
    inf_c  = (ec == 8'hFF) && (rdata_r[22:0] == 23'd0);
    sp_nxt   = x_r[31] ^ w_r[15];
    prod_inf = inf_a || inf_b;
    zero_p   = zero_a || zero_b;
    is_nan = nan_a || nan_b || nan_c || (inf_a && zero_b) || (inf_b && zero_a) ||
             (prod_inf && inf_c && (sp_nxt != rdata_r[31]));
    // A zero product passes the row through untouched, since its nominal exponent
    // could push the addend out of the window.
    if (is_nan) begin
      spec_val_nxt = CANON_NAN;
    end else if (prod_inf) begin
      spec_val_nxt = {sp_nxt, 8'hFF, 23'd0};
    end else if (zero_p && (rdata_r[30:0] == 31'd0)) begin
      spec_val_nxt = {sp_nxt & rdata_r[31], 31'd0};
    end else begin
      spec_val_nxt = rdata_r;
    end
    pm_nxt = {8'd0, ma} * {24'd0, mb};
    // The window puts the product at bits 57:26 and the addend at the top,
    // 89:66; whichever lies far below the other is shifted down with sticky.
    sh_p = dd - 11'sd8;
    sh_c = 11'sd40 - dd;
    if (dd > 11'sd40) begin
      rp_nxt = (sh_p > 11'sd127) ? 7'd127 : sh_p[6:0];
      rc_nxt = 7'd0;
      e0_nxt = ecu - 11'sd66;
    end else begin
      rp_nxt = 7'd32;
      rc_nxt = (sh_c > 11'sd127) ? 7'd127 : sh_c[6:0];
      e0_nxt = ep - 11'sd26;
    end
  end

  // Alignment step.
  logic [WIN_W-1:0] p_full, c_full, p_sh, c_sh;
  logic             p_lost, c_lost;

  always_comb begin
    p_full = {pm_r, 58'd0};
    c_full = {mc_r, 66'd0};
    p_sh   = p_full >> rp_r;
    c_sh   = c_full >> rc_r;
    p_lost = |(p_full & ~({WIN_W{1'b1}} << rp_r));
    c_lost = |(c_full & ~({WIN_W{1'b1}} << rc_r));
  end

  // Add step.
  logic [SUM_W-1:0] sum_pc, diff_pc, diff_cp, s_nxt;
  logic             sg_nxt;

  always_comb begin
    sum_pc  = {1'b0, pal_r} + {1'b0, cal_r};
    diff_pc = {1'b0, pal_r} - {1'b0, cal_r};
    diff_cp = {1'b0, cal_r} - {1'b0, pal_r};
    if (sp_r == sc_r) begin
      s_nxt  = sum_pc;
      sg_nxt = sp_r;
    end else if (!diff_pc[SUM_W-1]) begin
      s_nxt  = diff_pc;
      sg_nxt = (diff_pc == '0) ? 1'b0 : sp_r;
    end else begin
      s_nxt  = diff_cp;
      sg_nxt = sc_r;
    end
  end

  // Leading-one search, first within 16-bit chunks, then across chunks.
  logic [95:0] s_pad;
  logic [5:0]  nz_nxt;
  logic [3:0]  pos_nxt [6];
  logic [6:0]  l_nxt;

  always_comb begin
    s_pad = {5'd0, s_r};
    for (int k = 0; k < 6; k++) begin
      nz_nxt[k]  = |s_pad[16*k +: 16];
      pos_nxt[k] = 4'd0;
      for (int i = 0; i < 16; i++) begin
        if (s_pad[16*k + i]) begin
          pos_nxt[k] = 4'(i);
        end
      end
    end
    l_nxt = 7'd0;
    for (int k = 0; k < 6; k++) begin
      if (nz_r[k]) begin
        l_nxt = 7'(16 * k) + {3'b000, pos_r[k]};
      end
    end
  end

  // Shift step: the result's LSB sits 23 below the leading one, but never
  // below the smallest subnormal.
  logic signed [10:0] qa, qb, q, ef_nxt;
  logic [6:0]         qc;
  logic [SUM_W-1:0]   m_full, lower, half;
  logic [23:0]        m_nxt;
  logic               rnd_nxt, stk_nxt;

  always_comb begin
    qa = $signed({4'b0000, l_r}) - 11'sd23;
    qb = -11'sd149 - e0_r;
    q  = (qa > qb) ? qa : qb;
    qc = 7'd0;
    m_full = '0;
    lower = '0;
    half = '0;
    rnd_nxt = 1'b0;
    stk_nxt = 1'b0;
    if (q < 11'sd0) begin
      m_full = s_r << 7'(-q);
    end else begin
      qc = (q > 11'sd127) ? 7'd127 : q[6:0];
      m_full = s_r >> qc;
      if (qc != 7'd0) begin
        lower   = s_r & ~({SUM_W{1'b1}} << qc);
        half    = {{(SUM_W-1){1'b0}}, 1'b1} << (qc - 7'd1);
        rnd_nxt = |(s_r & half);
        stk_nxt = |(lower & ~half);
      end
    end
    m_nxt  = m_full[23:0];
    ef_nxt = m_full[23] ? (q + e0_r + 11'sd150) : 11'sd0;
  end

  // Round step; a carry out of the mantissa lands in the exponent field.
  logic [30:0]      mag;
  logic             inc;
  logic [VAL_W-1:0] result;

  always_comb begin
    inc = rnd_r && (stk_r || m_r[0]);
    if (ef_r >= 11'sd255) begin
      mag = {8'hFF, 23'd0};
    end else begin
      mag = {ef_r[7:0], m_r[22:0]} + {30'd0, inc};
    end
    result = spec_r ? spec_val_r : {sg_r, mag};
  end

  // Memory port control.
  always_comb begin
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = in_row;
    mem_wdata = '0;
    if (state_r == ST_IDLE && in_acc) begin
      case (cmd_t'(in_tuser))
        CMD_ACC:  mem_re = row_win && col_win;
        CMD_CLR:  mem_we = row_win;
        CMD_READ: mem_re = 1'b1;
        default:  mem_re = 1'b0;
      endcase
    end else if (state_r == ST_RND) begin
      mem_we    = 1'b1;
      mem_waddr = row_r;
      mem_wdata = result;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      acc_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= acc_mem[in_row];
    end
  end

  // Sequencer, window registers and output word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
      row_first_r  <= '0;
      row_end_r    <= CFG_W'(MAX_ROWS);
      col_first_r  <= '0;
      col_end_r    <= CFG_W'(MAX_COLS);
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_ROW_FIRST: row_first_r <= cfg_data;
          REG_ROW_END:   row_end_r   <= cfg_data;
          REG_COL_FIRST: col_first_r <= cfg_data;
          REG_COL_END:   col_end_r   <= cfg_data;
          default:       row_first_r <= row_first_r;
        endcase
      end
      // The read-out state refills the output register itself.
      if (out_tvalid_r && out_tready && state_r != ST_RDO) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          row_r <= in_row;
          x_r   <= in_tdata[71:40];
          w_r   <= in_tdata[39:24];
          if (in_acc) begin
            case (cmd_t'(in_tuser))
              CMD_ACC:  state_r <= (row_win && col_win) ? ST_DEC : ST_IDLE;
              CMD_READ: state_r <= ST_RDO;
              default:  state_r <= ST_IDLE;
            endcase
          end
        end
        ST_DEC: begin
          pm_r       <= pm_nxt;
          mc_r       <= mc;
          sp_r       <= sp_nxt;
          sc_r       <= rdata_r[31];
          rp_r       <= rp_nxt;
          rc_r       <= rc_nxt;
          e0_r       <= e0_nxt;
          spec_r     <= is_nan || prod_inf || inf_c || zero_p;
          spec_val_r <= spec_val_nxt;
          state_r    <= ST_ALN;
        end
        ST_ALN: begin
          pal_r   <= p_sh | {{(WIN_W-1){1'b0}}, p_lost};
          cal_r   <= c_sh | {{(WIN_W-1){1'b0}}, c_lost};
          state_r <= ST_ADD;
        end
        ST_ADD: begin
          s_r     <= s_nxt;
          sg_r    <= sg_nxt;
          state_r <= ST_NRM1;
        end
        ST_NRM1: begin
          nz_r    <= nz_nxt;
          pos_r   <= pos_nxt;
          state_r <= ST_NRM2;
        end
        ST_NRM2: begin
          l_r     <= l_nxt;
          state_r <= ST_SHF;
        end
        ST_SHF: begin
          m_r     <= m_nxt;
          rnd_r   <= rnd_nxt;
          stk_r   <= stk_nxt;
          ef_r    <= ef_nxt;
          state_r <= ST_RND;
        end
        ST_RND: begin
          state_r <= ST_IDLE;
        end
        ST_RDO: begin
          if (!out_tvalid_r || out_tready) begin
            out_tdata_r  <= {4'd0, row_r, rdata_r};
            out_tvalid_r <= 1'b1;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

/* rtl/bf16mv_checker.sv */
// Port-level checker for the BF16 weight matrix-vector accumulator, bound to the top.
// Depends on bf16mv_pkg and the assertion macro header.
`include "bf16_weight_matvec_accumulator_assert.svh"

module bf16mv_checker
  import bf16mv_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [IN_TDATA_W-1:0]  in_tdata,
  input logic [1:0]             in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   cfg_valid,
  input logic                   cfg_ready,
  input logic [1:0]             cfg_index,
  input logic [CFG_W-1:0]       cfg_data
);

  // A stalled result word holds.
  `BMV_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // A new result word follows a read word accepted in idle, by way of the read-out state.
  `BMV_IMPLIES(a_out_from_read, $rose(out_tvalid), $past(in_tvalid && in_tready && in_tuser == CMD_READ, 2))

  // The row number returned is the row that was asked for.
  `BMV_IMPLIES(a_row_echo, $rose(out_tvalid), out_tdata[43:32] == $past(in_tdata[11:0], 2))

  // After a read word the input side pauses while the row is fetched.
  `BMV_NEXT(a_read_stalls, in_tvalid && in_tready && in_tuser == CMD_READ, !in_tready)

endmodule

bind bf16_weight_matvec_accumulator bf16mv_checker u_bf16mv_checker (.*);

/* bench/tb_bf16_weight_matvec_accumulator.sv */
// Self-checking testbench for bf16_weight_matvec_accumulator: drives command words,
// predicts every row read with its own FP32 fused multiply-add and row store.
// Depends on bf16mv_pkg and the top level of the block.
`timescale 1ns / 1ps

module tb_bf16_weight_matvec_accumulator;
  import bf16mv_pkg::*;

  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int IDLE_LIMIT = 2000;

  class row_store_scoreboard;
    typedef struct packed {
      logic [VAL_W-1:0] value;
      logic [11:0]      row;
    } row_read_t;

    logic [VAL_W-1:0] acc_mem [MAX_ROWS];
    bit               written [MAX_ROWS];
    int               live_rows [$];
    row_read_t        pending [$];
    logic [CFG_W-1:0] row_lo = 0, row_hi = 4096, col_lo = 0, col_hi = 4096;

    function void set_reg(reg_idx_t idx, logic [CFG_W-1:0] v);
      case (idx)
        REG_ROW_FIRST: row_lo = v;
        REG_ROW_END:   row_hi = v;
        REG_COL_FIRST: col_lo = v;
        default:       col_hi = v;
      endcase
    endfunction

    function bit row_in(logic [11:0] row);
      return {1'b0, row} >= row_lo && {1'b0, row} < row_hi;
    endfunction

    function bit col_in(logic [11:0] col);
      return {1'b0, col} >= col_lo && {1'b0, col} < col_hi;
    endfunction

    function void mark(logic [11:0] row);
      if (!written[row]) begin
        written[row] = 1'b1;
        live_rows.push_back(row);
      end
    endfunction

    static function void unpack(logic [31:0] b, output logic [63:0] m, output int e);
      if (b[30:23] == 8'd0) begin
        m = 64'(b[22:0]);
        e = -149;
      end else begin
        m = 64'({1'b1, b[22:0]});
        e = int'(b[30:23]) - 150;
      end
    endfunction

    // Rounds sign * mag * 2^e0 to binary32, nearest even, subnormals kept.
    static function logic [31:0] round_pack(bit s, logic [255:0] mag, int e0);
      int p, q, r;
      logic [255:0] sg;
      bit half, rest;
      p = -1;
      half = 0;
      rest = 0;
      for (int i = 255; i >= 0; i--) begin
        if (mag[i]) begin
          p = i;
          break;
        end
      end
      if (p < 0) return {s, 31'd0};
      q = p + e0 - 23;
      if (q < -149) q = -149;
      r = q - e0;
      if (r <= 0) begin
        sg = mag << (-r);
      end else begin
        sg = mag >> r;
        half = mag[r-1];
        if (r >= 2) rest = |(mag & ((256'd1 << (r - 1)) - 256'd1));
        if (half && (rest || sg[0])) sg = sg + 256'd1;
      end
      if (sg[24]) begin
        sg = sg >> 1;
        q++;
      end
      if (sg[23]) begin
        if (q + 150 >= 255) return {s, 8'hFF, 23'd0};
        return {s, 8'(q + 150), sg[22:0]};
      end
      return {s, 8'h00, sg[22:0]};
    endfunction

    // Places m * 2^e on a grid whose bit 1 weighs 2^emin; bit 0 is a sticky bit.
    static function logic [255:0] align(logic [63:0] m, int e, int emin);
      int sh;
      if (e >= emin) return 256'(m) << (e - emin + 1);
      sh = emin - e;
      if (sh >= 64) return 256'd1;
      return (256'(m >> sh) << 1) | 256'(|(m & ((64'd1 << sh) - 64'd1)));
    endfunction

    static function logic [31:0] fused_mac(logic [31:0] x, logic [15:0] w, logic [31:0] c);
      logic [31:0] wf;
      logic [63:0] mx, mw, mc, mp;
      int ex, ew, ec, ep, emin;
      bit sp, p_inf, p_zero, s;
      logic [255:0] va, vc, mag;
      wf = {w, 16'd0};
      if ((x[30:23] == 8'hFF && x[22:0] != 0) || (wf[30:23] == 8'hFF && wf[22:0] != 0) ||
          (c[30:23] == 8'hFF && c[22:0] != 0))
        return CANON_NAN;
      sp = x[31] ^ wf[31];
      p_inf = (x[30:0] == 31'h7F800000) || (wf[30:0] == 31'h7F800000);
      p_zero = (x[30:0] == 0) || (wf[30:0] == 0);
      if (p_inf && p_zero) return CANON_NAN;
      if (c[30:0] == 31'h7F800000) begin
        if (p_inf && sp != c[31]) return CANON_NAN;
        return c;
      end
      if (p_inf) return {sp, 8'hFF, 23'd0};
      if (p_zero) begin
        if (c[30:0] == 0) return {sp & c[31], 31'd0};
        return c;
      end
      unpack(x, mx, ex);
      unpack(wf, mw, ew);
      mp = mx * mw;
      ep = ex + ew;
      if (c[30:0] == 0) return round_pack(sp, 256'(mp), ep);
      unpack(c, mc, ec);
      emin = ((ep > ec) ? ep : ec) - 150;
      va = align(mp, ep, emin);
      vc = align(mc, ec, emin);
      if (sp == c[31]) begin
        mag = va + vc;
        s = sp;
      end else if (va > vc) begin
        mag = va - vc;
        s = sp;
      end else if (vc > va) begin
        mag = vc - va;
        s = c[31];
      end else begin
        return 32'd0;
      end
      return round_pack(s, mag, emin - 1);
    endfunction

    function void note_word(logic [1:0] cmd, logic [11:0] row, logic [11:0] col,
                            logic [15:0] w, logic [31:0] x);
      case (cmd)
        CMD_ACC: if (row_in(row) && col_in(col)) begin
          acc_mem[row] = fused_mac(x, w, acc_mem[row]);
          mark(row);
        end
        CMD_CLR: if (row_in(row)) begin
          acc_mem[row] = 32'd0;
          mark(row);
        end
        CMD_READ: pending.push_back({acc_mem[row], row});
        default: ;
      endcase
    endfunction

    function bit check_read(logic [OUT_TDATA_W-1:0] word, output string why);
      row_read_t exp_rd;
      why = "";
      if (pending.size() == 0) begin
        $sformat(why, "row %0d returned with no read pending", word[43:32]);
        return 0;
      end
      exp_rd = pending.pop_front();
      if (word[43:32] != exp_rd.row)
        $sformat(why, "row_number %0d, want %0d", word[43:32], exp_rd.row);
      else if (word[31:0] != exp_rd.value)
        $sformat(why, "row %0d value %h, want %h", exp_rd.row, word[31:0], exp_rd.value);
      return why == "";
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [1:0]             in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [1:0]             cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;

  row_store_scoreboard sb = new();
  int  fail_count = 0;
  int  idle_cycles = 0;
  int  out_stall = 0;
  bit  no_gaps = 0;

  bf16_weight_matvec_accumulator i_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report(string why);
    fail_count++;
    $display("MISMATCH at %0t: %s", $realtime, why);
  endtask

  // Result side: check each read word, then draw the stall before the next one.
  always @(posedge clk) begin
    string why;
    if (rst_n && out_tvalid && out_tready) begin
      if (!sb.check_read(out_tdata, why)) report(why);
      out_stall = no_gaps ? 0 : $urandom_range(0, 17);
    end else if (out_stall > 0) begin
      out_stall--;
    end
    out_tready <= rst_n && out_stall == 0;
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready) ||
        !rst_n)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_word(logic [1:0] cmd, logic [11:0] row, logic [11:0] col,
                           logic [15:0] w, logic [31:0] x);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {x, w, col, row};
    do @(posedge clk); while (!in_tready);
    sb.note_word(cmd, row, col, w, x);
  endtask

  // Leaves cfg_valid high so that writes can follow back to back.
  task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, v);
  endtask

  // Lets all reads return, then covers an accumulate still in the pipeline.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_fp32();
    logic [31:0] specials [10] = '{32'h0, 32'h80000000, 32'h7F800000, 32'hFF800000,
                                   32'h7FC00000, 32'h00000001, 32'h807FFFFF,
                                   32'h7F7FFFFF, 32'h00800000, 32'hFFFFFFFF};
    case ($urandom_range(0, 19))
      0: return $urandom;
      1: return specials[$urandom_range(0, 9)];
      2: return {1'($urandom), 8'h00, 23'($urandom)};
      default: return {1'($urandom), 8'($urandom_range(118, 136)), 23'($urandom)};
    endcase
  endfunction

  function automatic logic [15:0] rand_bf16();
    logic [15:0] specials [9] = '{16'h0000, 16'h8000, 16'h7F80, 16'hFF80, 16'h7FC0,
                                  16'h0001, 16'h7F7F, 16'hFFFF, 16'h0080};
    case ($urandom_range(0, 19))
      0: return 16'($urandom);
      1: return specials[$urandom_range(0, 8)];
      2: return {1'($urandom), 8'h00, 7'($urandom)};
      default: return {1'($urandom), 8'($urandom_range(118, 136)), 7'($urandom)};
    endcase
  endfunction

  function automatic logic [11:0] pick_live();
    return 12'(sb.live_rows[$urandom_range(0, sb.live_rows.size() - 1)]);
  endfunction

  function automatic logic [11:0] pick_row();
    if ($urandom_range(0, 1)) return 12'($urandom);
    return $urandom_range(0, 1) ? 12'($urandom_range(0, 31)) : 12'($urandom_range(4064, 4095));
  endfunction

  // One random word; returns 0 for a spare command, which the block drops.
  task automatic random_word(output bit counted);
    logic [1:0]  cmd;
    logic [11:0] row, col;
    int r;
    r = $urandom_range(0, 99);
    col = 12'($urandom);
    if (sb.col_hi > sb.col_lo && $urandom_range(0, 4) != 0)
      col = 12'($urandom_range(sb.col_lo, sb.col_hi - 1));
    if (r < 6) begin
      cmd = CMD_SPARE;
      row = 12'($urandom);
    end else if (r < 20 || sb.live_rows.size() == 0) begin
      cmd = CMD_CLR;
      row = pick_row();
    end else if (r < 38) begin
      cmd = CMD_READ;
      row = pick_live();
    end else begin
      cmd = CMD_ACC;
      row = $urandom_range(0, 6) != 0 ? pick_live() : pick_row();
      // Never accumulate into a row that has not been written yet.
      if (!sb.written[row] && sb.row_in(row) && sb.col_in(col)) cmd = CMD_CLR;
    end
    send_word(cmd, row, col, rand_bf16(), rand_fp32());
    counted = cmd != CMD_SPARE;
  endtask

  initial begin
    logic [CFG_W-1:0] windows [7][4] = '{
      '{13'd0,    13'd4096, 13'd0,    13'd4096},
      '{13'd16,   13'd48,   13'd100,  13'd3000},
      '{13'd4096, 13'd4096, 13'd0,    13'd4096},
      '{13'd0,    13'd4096, 13'd4000, 13'd4096},
      '{13'd40,   13'd20,   13'd0,    13'd4096},
      '{13'd1,    13'd4095, 13'd1,    13'd4095},
      '{13'd0,    13'd4096, 13'd0,    13'd0}};
    int sent;
    bit counted;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words: clears at both ends of the store, special operands, read-backs and a spare word.
    send_word(CMD_CLR, 12'd0, 12'd0, 16'h0, 32'h0);
    send_word(CMD_CLR, 12'd4095, 12'd0, 16'h0, 32'h0);
    send_word(CMD_CLR, 12'd1, 12'd0, 16'h0, 32'h0);
    send_word(CMD_CLR, 12'd2, 12'd0, 16'h0, 32'h0);
    send_word(CMD_CLR, 12'd3, 12'd0, 16'h0, 32'h0);
    send_word(CMD_ACC, 12'd0, 12'd0, 16'h3F80, 32'h3F800000);
    send_word(CMD_ACC, 12'd1, 12'd4095, 16'h7F80, 32'h00000000);
    send_word(CMD_ACC, 12'd2, 12'd7, 16'h7F80, 32'h3F800000);
    send_word(CMD_ACC, 12'd2, 12'd8, 16'hFF80, 32'h3F800000);
    send_word(CMD_ACC, 12'd3, 12'd9, 16'h0001, 32'h00000001);
    send_word(CMD_ACC, 12'd3, 12'd9, 16'h7F7F, 32'h7F7FFFFF);
    send_word(CMD_ACC, 12'd4095, 12'd4095, 16'h8000, 32'h80000000);
    send_word(CMD_ACC, 12'd4095, 12'd4095, 16'h3F80, 32'h00000001);
    send_word(CMD_READ, 12'd0, 12'd0, 16'h0, 32'h0);
    send_word(CMD_READ, 12'd1, 12'd0, 16'h0, 32'h0);
    send_word(CMD_READ, 12'd2, 12'd0, 16'h0, 32'h0);
    send_word(CMD_READ, 12'd3, 12'd0, 16'h0, 32'h0);
    send_word(CMD_READ, 12'd4095, 12'd0, 16'h0, 32'h0);
    send_word(CMD_SPARE, 12'd5, 12'hFFF, 16'hFFFF, 32'hFFFFFFFF);
    send_word(CMD_ACC, 12'd0, 12'd1, 16'hBF80, 32'h3F800000);
    send_word(CMD_READ, 12'd0, 12'd0, 16'h0, 32'h0);
    send_word(CMD_ACC, 12'd4095, 12'd2, 16'hFFC1, 32'h3F800000);
    send_word(CMD_READ, 12'd4095, 12'd0, 16'h0, 32'h0);

    for (int ph = 0; ph < 7; ph++) begin
      drain();
      for (int k = 0; k < 4; k++) write_reg(reg_idx_t'(k), windows[ph][k]);
      cfg_valid <= 1'b0;
      sent = 0;
      while (sent < 260) begin
        if ($urandom_range(0, 59) == 0) no_gaps = !no_gaps;
        random_word(counted);
        if (counted) sent++;
      end
    end

    no_gaps = 0;
    drain();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
